// ----- design/cke_pkg.sv -----
package cke_pkg;

  localparam int MAX_K = 31;
  localparam int K_W = 5;
  localparam int KMER_W = 2 * MAX_K;
  localparam int RUN_W = 6;
  localparam int RUN_MAX = 32;
  localparam int SLOT_W = 3;
  localparam int CODE_W = 2;
  localparam int SHIFT_W = 7;

  localparam logic [K_W-1:0] KMER_LEN_RESET = K_W'(MAX_K);

  // base codes
  localparam logic [CODE_W-1:0] CODE_A = 2'd0;
  localparam logic [CODE_W-1:0] CODE_C = 2'd1;
  localparam logic [CODE_W-1:0] CODE_G = 2'd2;
  localparam logic [CODE_W-1:0] CODE_T = 2'd3;

  // complement of a 2-bit base code
  localparam logic [CODE_W-1:0] COMP_XOR = 2'd3;
  // slot offset for the "other form" half
  localparam logic [SLOT_W-1:0] SLOT_HI = 3'd4;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
  } base_t;

  typedef struct packed {
    logic [KMER_W-1:0] from_key;
    logic [SLOT_W-1:0] from_slot;
    logic [KMER_W-1:0] to_key;
    logic [SLOT_W-1:0] to_slot;
  } edge_t;

  function automatic base_t base_decode(input logic [7:0] ch);
    base_t b;
    b.ok = 1'b1;
    unique case (ch)
      8'h41, 8'h61: b.code = CODE_A;
      8'h43, 8'h63: b.code = CODE_C;
      8'h47, 8'h67: b.code = CODE_G;
      8'h54, 8'h74: b.code = CODE_T;
      default: begin
        b.ok = 1'b0;
        b.code = CODE_A;
      end
    endcase
    return b;
  endfunction

endpackage

// ----- design/cke_datapath.sv -----
module cke_datapath
  import cke_pkg::*;
(
  input  logic [KMER_W-1:0] fwd,
  input  logic [KMER_W-1:0] rev,
  input  logic [RUN_W-1:0]  run,
  input  base_t             base,
  input  logic              start,
  input  logic [K_W-1:0]    kmer_length,
  output logic [KMER_W-1:0] fwd_next,
  output logic [KMER_W-1:0] rev_next,
  output logic [RUN_W-1:0]  run_next,
  output logic              hit,
  output edge_t             edge_out
);

  logic [K_W-1:0]     k_eff;
  logic [RUN_W-1:0]   two_k;
  logic [RUN_W-1:0]   top;
  logic [KMER_W-1:0]  mask;
  logic [KMER_W-1:0]  cur_fwd;
  logic [KMER_W-1:0]  cur_rev;
  logic [RUN_W-1:0]   cur_run;
  logic [KMER_W-1:0]  ins_rev;
  logic [CODE_W-1:0]  dropped;
  logic               from_is_fwd;
  logic               to_is_fwd;

  always_comb begin
    k_eff = (kmer_length == '0) ? K_W'(1) : kmer_length;
    two_k = {k_eff, 1'b0};
    top = two_k - RUN_W'(2);
    mask = {KMER_W{1'b1}} >> (SHIFT_W'(KMER_W) - SHIFT_W'(two_k));

    // read start wipes state before this base
    cur_fwd = start ? '0 : fwd;
    cur_rev = start ? '0 : rev;
    cur_run = start ? '0 : run;

    ins_rev = {{(KMER_W-CODE_W){1'b0}}, base.code ^ COMP_XOR} << top;

    fwd_next = (cur_fwd << 2) & mask;
    rev_next = (cur_rev >> 2) & mask;
    if (base.ok) begin
      fwd_next = fwd_next | {{(KMER_W-CODE_W){1'b0}}, base.code};
      rev_next = rev_next | ins_rev;
      run_next = (cur_run < RUN_W'(RUN_MAX)) ? cur_run + RUN_W'(1) : cur_run;
    end else begin
      run_next = '0;
    end

    hit = base.ok && (run_next >= RUN_W'(k_eff) + RUN_W'(1));

    // previous k-mer is the stored one, top base at the current length
    dropped = CODE_W'(cur_fwd >> top);
    from_is_fwd = cur_fwd < cur_rev;
    to_is_fwd = fwd_next < rev_next;

    edge_out.from_key = from_is_fwd ? cur_fwd : cur_rev;
    edge_out.from_slot = {1'b0, base.code} | (from_is_fwd ? '0 : SLOT_HI);
    edge_out.to_key = to_is_fwd ? fwd_next : rev_next;
    edge_out.to_slot = {1'b0, dropped ^ COMP_XOR} | (to_is_fwd ? SLOT_HI : '0);
  end

endmodule

// ----- design/canonical_kmer_edge_extractor_core.sv -----
// Canonical k-mer edge extractor. Feed one read character per item, with
// read_start high on the first character of each read. A, C, G, T (either
// case) extend the current run; any other character breaks it but still
// shifts the window. Once kmer_length+1 valid bases have been seen in a row,
// every valid base produces one edge item: canonical keys of the previous
// and current k-mer (smaller of forward and reverse complement, reverse on
// a tie) plus a 3-bit slot at each end. Other characters produce nothing.
// Rate: one item per cycle unless the result side stalls. The character
// is decoded into an input register, then the shift, the two 62-bit
// compares and the key select run in one step into the result register.
// The rolling k-mer state updates in that same step, so back-to-back bases
// chain through it. Stalling the result side holds the input register and
// raises in_stall. kmer_length (reset 31, zero acts as 1) is written on the
// cfg channel, which is always ready; write it only while no item is in
// flight.
module canonical_kmer_edge_extractor_core
  import cke_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // config write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [K_W-1:0]    cfg_data,
  // character items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        base_char,
  input  logic              read_start,
  // edge items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KMER_W-1:0] from_key,
  output logic [SLOT_W-1:0] from_slot,
  output logic [KMER_W-1:0] to_key,
  output logic [SLOT_W-1:0] to_slot
);

  logic [K_W-1:0]    kmer_length;

  // input register
  logic              s1_valid;
  base_t             s1_base;
  logic              s1_start;

  // rolling state
  logic [KMER_W-1:0] fwd;
  logic [KMER_W-1:0] rev;
  logic [RUN_W-1:0]  run;

  logic [KMER_W-1:0] fwd_next;
  logic [KMER_W-1:0] rev_next;
  logic [RUN_W-1:0]  run_next;
  logic              hit;
  edge_t             edge_c;
  edge_t             result;

  logic              advance;
  logic              in_take;

  assign cfg_ready = 1'b1;

  // step the input register whenever the result register can take a value
  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      kmer_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_base <= base_decode(base_char);
      s1_start <= read_start;
    end
  end

  cke_datapath u_datapath (
    .fwd         (fwd),
    .rev         (rev),
    .run         (run),
    .base        (s1_base),
    .start       (s1_start),
    .kmer_length (kmer_length),
    .fwd_next    (fwd_next),
    .rev_next    (rev_next),
    .run_next    (run_next),
    .hit         (hit),
    .edge_out    (edge_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      rev <= '0;
      run <= '0;
    end else if (advance) begin
      fwd <= fwd_next;
      rev <= rev_next;
      run <= run_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      result <= edge_c;
    end
  end

  assign from_key = result.from_key;
  assign from_slot = result.from_slot;
  assign to_key = result.to_key;
  assign to_slot = result.to_slot;

`ifndef SYNTHESIS
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    advance && s1_start |=> run <= RUN_W'(1))
    else $error("run count not cleared by read start");

  a_run_sat: assert property (@(posedge clk) disable iff (rst)
    advance |=> run <= RUN_W'(RUN_MAX))
    else $error("run count past saturation");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a held result");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && hit))
    else $error("result appeared without a processed edge");

  a_bad_char_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_base.ok |=> !out_valid && run == '0)
    else $error("invalid base produced an edge");
`endif

endmodule
